// File: rtl/erf_pkg.sv
// Shared types and constants for the echo range spike filter.
// Holds the register indexes, reset values and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package erf_pkg;

	localparam int PULSE_WIDTH_BITS_DEF = 13;

	localparam int DIST_W   = 12;
	localparam int REJ_W    = 10;
	localparam int CNT_W    = 6;
	localparam int CFG_IDX_W = 3;

	localparam int SCALE_MUL_W = 10;
	localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 10'd557;
	localparam int SCALE_SHIFT = 11;

	localparam logic [DIST_W-1:0] DIST_MAX = 12'd4095;
	localparam logic [REJ_W-1:0]  REJ_MAX  = 10'd1023;
	localparam logic [CNT_W-1:0]  STAB_MAX = 6'd63;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_TOLERANCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_NEEDED    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_SAMPLES   = 3'd6;

	localparam logic [DIST_W-1:0] RST_MIN_DISTANCE     = 12'd160;
	localparam logic [DIST_W-1:0] RST_MAX_DISTANCE     = 12'd1600;
	localparam logic [DIST_W-1:0] RST_JUMP_LIMIT       = 12'd320;
	localparam logic [DIST_W-1:0] RST_STABLE_TOLERANCE = 12'd80;
	localparam logic [CNT_W-1:0]  RST_STABLE_NEEDED    = 6'd30;
	localparam logic [REJ_W-1:0]  RST_RETRY_LIMIT      = 10'd999;
	localparam logic [CNT_W-1:0]  RST_WARMUP_SAMPLES   = 6'd50;
	localparam logic [DIST_W-1:0] RST_HELD_DISTANCE    = 12'd320;

	typedef struct packed {
		logic [DIST_W-1:0] min_distance;
		logic [DIST_W-1:0] max_distance;
		logic [DIST_W-1:0] jump_limit;
		logic [DIST_W-1:0] stable_tolerance;
		logic [CNT_W-1:0]  stable_needed;
		logic [REJ_W-1:0]  retry_limit;
		logic [CNT_W-1:0]  warmup_samples;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/erf_conv.sv
// Converts an echo pulse width in microseconds to a distance in 1/16 cm.
// Constant multiply, shift and saturation; flags a timeout on zero width.
// Depends on erf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erf_conv #(
	parameter int PULSE_WIDTH_BITS = erf_pkg::PULSE_WIDTH_BITS_DEF
) (
	input  wire logic [PULSE_WIDTH_BITS-1:0] pulse_width,
	output logic [erf_pkg::DIST_W-1:0]       cur,
	output logic                             timeout
);
	import erf_pkg::*;

	localparam int PROD_W = PULSE_WIDTH_BITS + SCALE_MUL_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] shifted;

	always_comb begin
		prod    = PROD_W'(pulse_width) * PROD_W'(SCALE_MUL);
		shifted = prod >> SCALE_SHIFT;
		timeout = (pulse_width == '0);
		if (shifted > PROD_W'(DIST_MAX)) begin
			cur = DIST_MAX;
		end else begin
			cur = shifted[DIST_W-1:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/erf_track.sv
// Filter state and accept or hold decision for one converted distance.
// Holds the held distance, the warm-up, reject and stable counters and the last outlier.
// Depends on erf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erf_track (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire erf_pkg::cfg_t               cfg,
	input  wire logic                        fire,
	input  wire logic [erf_pkg::DIST_W-1:0]  cur,
	input  wire logic                        timeout,
	output logic [erf_pkg::DIST_W-1:0]       distance,
	output logic                             held
);
	import erf_pkg::*;

	logic [DIST_W-1:0] held_distance_q;
	logic [REJ_W-1:0]  reject_count_q;
	logic [CNT_W-1:0]  warmup_count_q;
	logic [CNT_W-1:0]  stable_count_q;
	logic [DIST_W-1:0] last_outlier_q;

	logic              in_range;
	logic              warm;
	logic [DIST_W-1:0] diff_held;
	logic [DIST_W-1:0] diff_last;
	logic              outlier;
	logic [CNT_W-1:0]  stab_next;
	logic [REJ_W-1:0]  rej_next;
	logic              accept;

	always_comb begin
		in_range  = (cur >= cfg.min_distance) && (cur <= cfg.max_distance);
		warm      = (warmup_count_q < cfg.warmup_samples);
		diff_held = (cur > held_distance_q) ? cur - held_distance_q : held_distance_q - cur;
		diff_last = (cur > last_outlier_q) ? cur - last_outlier_q : last_outlier_q - cur;
		outlier   = !in_range || (diff_held > cfg.jump_limit);
		if (diff_last < cfg.stable_tolerance) begin
			stab_next = (stable_count_q == STAB_MAX) ? STAB_MAX : stable_count_q + 1'b1;
		end else begin
			stab_next = '0;
		end
		rej_next = (reject_count_q == REJ_MAX) ? REJ_MAX : reject_count_q + 1'b1;
		accept   = !outlier || !((rej_next < cfg.retry_limit) && (stab_next < cfg.stable_needed));

		if (timeout) begin
			distance = held_distance_q;
			held     = 1'b1;
		end else if (warm) begin
			distance = in_range ? cur : held_distance_q;
			held     = !in_range;
		end else begin
			distance = accept ? cur : held_distance_q;
			held     = !accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_distance_q <= RST_HELD_DISTANCE;
			reject_count_q  <= '0;
			warmup_count_q  <= '0;
			stable_count_q  <= '0;
			last_outlier_q  <= '0;
		end else if (fire && !timeout) begin
			if (warm) begin
				warmup_count_q <= warmup_count_q + 1'b1;
				if (in_range) begin
					held_distance_q <= cur;
				end
			end else begin
				if (outlier) begin
					last_outlier_q <= cur;
				end
				if (accept) begin
					held_distance_q <= cur;
					reject_count_q  <= '0;
					stable_count_q  <= '0;
				end else begin
					reject_count_q <= rej_next;
					stable_count_q <= stab_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/echo_range_spike_filter.sv
// Top level of the echo range spike filter: input register, configuration
// registers and result register around erf_conv and erf_track.
// Depends on erf_pkg, erf_conv and erf_track.
//
// Usage:
// Each input transfer on in_valid/in_ready carries one echo pulse width in
// microseconds; zero marks a timeout. Every input gives exactly one result
// transfer on out_valid/out_ready with the filtered distance in 1/16 cm and
// the held flag. The width is converted and registered in the input register;
// the filter decision is made from that register into the result register,
// which offers it. While the receiver takes results, throughput is one item
// per cycle, bounded by the update of the held distance and counters as each
// result is registered. When the receiver stalls, the result register
// holds its item and one more item waits in the input register; in_ready
// drops only when both are full.
// Configuration writes on cfg_valid/cfg_ready are always taken, one per cycle,
// and are meant to happen while no item is in flight.
// Reset clears the pipeline, restores the register defaults and sets the held
// distance to 20 cm with all counters at zero.
`timescale 1ns / 1ps
`default_nettype none

module echo_range_spike_filter #(
	parameter int PULSE_WIDTH_BITS = erf_pkg::PULSE_WIDTH_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [PULSE_WIDTH_BITS-1:0]   pulse_width,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [erf_pkg::DIST_W-1:0]         distance,
	output logic                               held,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [erf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [erf_pkg::DIST_W-1:0]    cfg_data
);
	import erf_pkg::*;

	cfg_t cfg_q;

	logic [DIST_W-1:0] conv_cur;
	logic              conv_timeout;

	logic              valid_s1;
	logic [DIST_W-1:0] cur_s1;
	logic              timeout_s1;

	logic              adv;
	logic [DIST_W-1:0] trk_distance;
	logic              trk_held;

	logic              out_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic              held_q;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign held      = held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_distance     <= RST_MIN_DISTANCE;
			cfg_q.max_distance     <= RST_MAX_DISTANCE;
			cfg_q.jump_limit       <= RST_JUMP_LIMIT;
			cfg_q.stable_tolerance <= RST_STABLE_TOLERANCE;
			cfg_q.stable_needed    <= RST_STABLE_NEEDED;
			cfg_q.retry_limit      <= RST_RETRY_LIMIT;
			cfg_q.warmup_samples   <= RST_WARMUP_SAMPLES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_DISTANCE:     cfg_q.min_distance     <= cfg_data;
				REG_MAX_DISTANCE:     cfg_q.max_distance     <= cfg_data;
				REG_JUMP_LIMIT:       cfg_q.jump_limit       <= cfg_data;
				REG_STABLE_TOLERANCE: cfg_q.stable_tolerance <= cfg_data;
				REG_STABLE_NEEDED:    cfg_q.stable_needed    <= cfg_data[CNT_W-1:0];
				REG_RETRY_LIMIT:      cfg_q.retry_limit      <= cfg_data[REJ_W-1:0];
				REG_WARMUP_SAMPLES:   cfg_q.warmup_samples   <= cfg_data[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	erf_conv #(
		.PULSE_WIDTH_BITS(PULSE_WIDTH_BITS)
	) u_conv (
		.pulse_width(pulse_width),
		.cur        (conv_cur),
		.timeout    (conv_timeout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cur_s1     <= conv_cur;
			timeout_s1 <= conv_timeout;
		end
	end

	erf_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.fire    (adv),
		.cur     (cur_s1),
		.timeout (timeout_s1),
		.distance(trk_distance),
		.held    (trk_held)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			distance_q <= trk_distance;
			held_q     <= trk_held;
		end
	end

endmodule

`default_nettype wire
